[sv/pqm_pkg.sv]
package pqm_pkg;

	// width of the value fields on the ports
	localparam int FIELD_W = 32;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PUSH0,
		ST_LOOP,
		ST_CK_RD,
		ST_CK_RUN,
		ST_POP_RD,
		ST_POP_DEC,
		ST_SW_RDF,
		ST_SW_RDM,
		ST_SW_WRF,
		ST_SW_WRM,
		ST_SC_RD,
		ST_SC_CMP,
		ST_SC_SWA,
		ST_SC_SWB,
		ST_FN_RD,
		ST_FN_WRF,
		ST_FN_WRE,
		ST_PUSH_R,
		ST_PUSH_L,
		ST_EM_RD,
		ST_EM_LD
	} pqm_state_t;

endpackage

[sv/pqm_ram.sv]
module pqm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/partial_quicksort_to_median_unit.sv]
// Loading: one cycle per value, in_ready high in idle.
// Sort: each median check streams the set and stops at the first violation; a partition of a
// range is popped, pivot swapped in from the middle, Lomuto-scanned, pivot placed, parts pushed.
// Output: one value per cycle while out_ready is high; block is busy until the last is loaded.
// Reset clears the sequencer, the item count, the stack pointer and out_valid; value and
// range RAM contents are undefined until written, and no clearing pass runs.
module partial_quicksort_to_median_unit #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pqm_pkg::FIELD_W-1:0] item_value,
	input  logic                      item_last,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic [pqm_pkg::FIELD_W-1:0] out_value,
	output logic                      out_last,
	output logic                      out_valid,
	input  logic                      out_ready
);

	import pqm_pkg::*;

	localparam int IW = $clog2(MAX_ITEMS);     // index width
	localparam int CW = $clog2(MAX_ITEMS + 1); // count width
	localparam int VW = VALUE_WIDTH;
	localparam int SW = 2 * IW;                // stack entry: first, last

	// ---------------------------------------------------------------------------------------
	// State
	// ---------------------------------------------------------------------------------------
	pqm_state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;     // values held for the set being loaded
	logic [CW-1:0] n_q, n_d;         // set size being sorted / emitted
	logic [CW-1:0] sp_q, sp_d;       // ranges on the stack
	logic [IW-1:0] k_q, k_d;         // walking index (check, scan, emit)
	logic [IW-1:0] first_q, first_d; // current range
	logic [IW-1:0] last_q, last_d;
	logic [IW-1:0] edge_q, edge_d;   // Lomuto boundary
	logic [VW-1:0] opnd_q, opnd_d;   // compare operand: running prev in check, pivot in split
	logic [VW-1:0] tmp_q, tmp_d;     // held value for swaps

	logic                out_valid_q;
	logic [FIELD_W-1:0]  out_value_q, out_value_d;
	logic                out_last_q, out_last_d;
	logic                ld_out;

	// value RAM port
	logic          v_we, v_re;
	logic [IW-1:0] v_waddr, v_raddr;
	logic [VW-1:0] v_wdata, v_rdata;

	// range stack RAM port
	logic          s_we, s_re;
	logic [IW-1:0] s_waddr, s_raddr;
	logic [SW-1:0] s_wdata, s_rdata;

	// ---------------------------------------------------------------------------------------
	// Shared helpers
	// ---------------------------------------------------------------------------------------
	logic          lt;        // the one value comparator: read data below the operand
	logic          cnt_full;
	logic [CW-1:0] n_new;
	logic [CW-1:0] n_m1;
	logic [CW:0]   n_p1;
	logic [CW-1:0] m_c;       // median index (n+1)/2
	logic [CW-1:0] k_ext;
	logic          k_at_end;  // k is the last index of the set
	logic [IW:0]   sum_fl;
	logic [IW-1:0] mid_idx;
	logic [IW-1:0] k_inc;
	logic [IW-1:0] edge_inc;
	logic [CW-1:0] sp_m1;
	logic [IW-1:0] pop_first, pop_last;
	logic          push_r_ok, push_l_ok;

	assign lt        = v_rdata < opnd_q;
	assign cnt_full  = cnt_q == CW'(MAX_ITEMS);
	assign n_new     = cnt_full ? cnt_q : cnt_q + CW'(1);
	assign n_m1      = n_q - CW'(1);
	assign n_p1      = {1'b0, n_q} + (CW + 1)'(1);
	assign m_c       = n_p1[CW:1];
	assign k_ext     = CW'(k_q);
	assign k_at_end  = k_ext == n_m1;
	assign sum_fl    = {1'b0, first_q} + {1'b0, last_q};
	assign mid_idx   = sum_fl[IW:1];
	assign k_inc     = k_q + IW'(1);
	assign edge_inc  = edge_q + IW'(1);
	assign sp_m1     = sp_q - CW'(1);
	assign pop_first = s_rdata[SW-1:IW];
	assign pop_last  = s_rdata[IW-1:0];
	// right part (p+1, last) and left part (first, p-1) only when two or more elements
	assign push_r_ok = (({1'b0, edge_q} + (IW + 1)'(1)) < {1'b0, last_q})
		&& (sp_q < CW'(MAX_ITEMS));
	assign push_l_ok = (({1'b0, first_q} + (IW + 1)'(1)) < {1'b0, edge_q})
		&& (sp_q < CW'(MAX_ITEMS));

	// ---------------------------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		n_d         = n_q;
		sp_d        = sp_q;
		k_d         = k_q;
		first_d     = first_q;
		last_d      = last_q;
		edge_d      = edge_q;
		opnd_d      = opnd_q;
		tmp_d       = tmp_q;
		out_value_d = out_value_q;
		out_last_d  = out_last_q;
		ld_out      = 1'b0;
		in_ready    = 1'b0;
		v_we        = 1'b0;
		v_waddr     = '0;
		v_wdata     = '0;
		v_re        = 1'b0;
		v_raddr     = '0;
		s_we        = 1'b0;
		s_waddr     = '0;
		s_wdata     = '0;
		s_re        = 1'b0;
		s_raddr     = '0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// values past the store size are dropped
					if (!cnt_full) begin
						v_we    = 1'b1;
						v_waddr = cnt_q[IW-1:0];
						v_wdata = VW'(item_value);
					end
					if (item_last) begin
						cnt_d   = '0;
						n_d     = n_new;
						sp_d    = '0;
						state_d = (n_new > CW'(1)) ? ST_PUSH0 : ST_EM_RD;
					end else begin
						cnt_d = n_new;
					end
				end
			end

			// whole set as the first range
			ST_PUSH0: begin
				s_we    = 1'b1;
				s_waddr = '0;
				s_wdata = {IW'(0), n_m1[IW-1:0]};
				sp_d    = CW'(1);
				state_d = ST_CK_RD;
			end

			ST_LOOP: begin
				state_d = (sp_q == '0) ? ST_EM_RD : ST_CK_RD;
			end

			// median check: one element a cycle, stop on the first violation
			ST_CK_RD: begin
				v_re    = 1'b1;
				v_raddr = '0;
				k_d     = '0;
				state_d = ST_CK_RUN;
			end

			ST_CK_RUN: begin
				if (k_q != '0 && lt) begin
					state_d = ST_POP_RD;
				end else if (k_at_end) begin
					state_d = ST_EM_RD;
				end else begin
					// operand freezes at element m for the tail
					if (k_ext <= m_c) begin
						opnd_d = v_rdata;
					end
					v_re    = 1'b1;
					v_raddr = k_inc;
					k_d     = k_inc;
				end
			end

			ST_POP_RD: begin
				s_re    = 1'b1;
				s_raddr = sp_m1[IW-1:0];
				sp_d    = sp_m1;
				state_d = ST_POP_DEC;
			end

			ST_POP_DEC: begin
				first_d = pop_first;
				last_d  = pop_last;
				if (pop_first >= pop_last || CW'(pop_last) >= n_q) begin
					state_d = ST_LOOP;
				end else begin
					state_d = ST_SW_RDF;
				end
			end

			// swap middle element to the front; it becomes the pivot
			ST_SW_RDF: begin
				v_re    = 1'b1;
				v_raddr = first_q;
				state_d = ST_SW_RDM;
			end

			ST_SW_RDM: begin
				tmp_d   = v_rdata;
				v_re    = 1'b1;
				v_raddr = mid_idx;
				state_d = ST_SW_WRF;
			end

			ST_SW_WRF: begin
				v_we    = 1'b1;
				v_waddr = first_q;
				v_wdata = v_rdata;
				opnd_d  = v_rdata;
				state_d = ST_SW_WRM;
			end

			ST_SW_WRM: begin
				v_we    = 1'b1;
				v_waddr = mid_idx;
				v_wdata = tmp_q;
				k_d     = first_q + IW'(1);
				edge_d  = first_q;
				state_d = ST_SC_RD;
			end

			// Lomuto scan over first+1 .. last
			ST_SC_RD: begin
				v_re    = 1'b1;
				v_raddr = k_q;
				state_d = ST_SC_CMP;
			end

			ST_SC_CMP: begin
				tmp_d = v_rdata;
				if (lt && edge_inc != k_q) begin
					edge_d  = edge_inc;
					v_re    = 1'b1;
					v_raddr = edge_inc;
					state_d = ST_SC_SWA;
				end else begin
					if (lt) begin
						edge_d = edge_inc;
					end
					if (k_q == last_q) begin
						state_d = ST_FN_RD;
					end else begin
						v_re    = 1'b1;
						v_raddr = k_inc;
						k_d     = k_inc;
					end
				end
			end

			ST_SC_SWA: begin
				v_we    = 1'b1;
				v_waddr = edge_q;
				v_wdata = tmp_q;
				state_d = ST_SC_SWB;
			end

			ST_SC_SWB: begin
				v_we    = 1'b1;
				v_waddr = k_q;
				v_wdata = v_rdata;
				if (k_q == last_q) begin
					state_d = ST_FN_RD;
				end else begin
					v_re    = 1'b1;
					v_raddr = k_inc;
					k_d     = k_inc;
					state_d = ST_SC_CMP;
				end
			end

			// pivot into its final place; front still holds the pivot
			ST_FN_RD: begin
				v_re    = 1'b1;
				v_raddr = edge_q;
				state_d = ST_FN_WRF;
			end

			ST_FN_WRF: begin
				v_we    = 1'b1;
				v_waddr = first_q;
				v_wdata = v_rdata;
				state_d = ST_FN_WRE;
			end

			ST_FN_WRE: begin
				v_we    = 1'b1;
				v_waddr = edge_q;
				v_wdata = opnd_q;
				state_d = ST_PUSH_R;
			end

			ST_PUSH_R: begin
				if (push_r_ok) begin
					s_we    = 1'b1;
					s_waddr = sp_q[IW-1:0];
					s_wdata = {edge_inc, last_q};
					sp_d    = sp_q + CW'(1);
				end
				state_d = ST_PUSH_L;
			end

			// left range pushed last so it is handled first
			ST_PUSH_L: begin
				if (push_l_ok) begin
					s_we    = 1'b1;
					s_waddr = sp_q[IW-1:0];
					s_wdata = {first_q, edge_q - IW'(1)};
					sp_d    = sp_q + CW'(1);
				end
				state_d = ST_LOOP;
			end

			ST_EM_RD: begin
				v_re    = 1'b1;
				v_raddr = '0;
				k_d     = '0;
				state_d = ST_EM_LD;
			end

			ST_EM_LD: begin
				if (!out_valid_q || out_ready) begin
					ld_out      = 1'b1;
					out_value_d = FIELD_W'(v_rdata);
					out_last_d  = k_at_end;
					if (k_at_end) begin
						state_d = ST_IDLE;
					end else begin
						v_re    = 1'b1;
						v_raddr = k_inc;
						k_d     = k_inc;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sp_q    <= sp_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q         <= n_d;
		k_q         <= k_d;
		first_q     <= first_d;
		last_q      <= last_d;
		edge_q      <= edge_d;
		opnd_q      <= opnd_d;
		tmp_q       <= tmp_d;
		out_value_q <= out_value_d;
		out_last_q  <= out_last_d;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

	// ---------------------------------------------------------------------------------------
	// Storage
	// ---------------------------------------------------------------------------------------
	pqm_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_ITEMS)
	) u_value_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.re   (v_re),
		.raddr(v_raddr),
		.rdata(v_rdata)
	);

	pqm_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_ITEMS)
	) u_stack_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.re   (s_re),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	// ---------------------------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------------------------
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_ITEMS))
		else $error("range stack pointer past depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_RD) |-> (sp_q != '0))
		else $error("pop from empty range stack");

	a_scan_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC_CMP) |-> (edge_q >= first_q && edge_q < k_q && k_q <= last_q))
		else $error("partition boundary outside scanned part");

	a_set_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && item_last) |=> (cnt_q == '0 && state_q != ST_IDLE))
		else $error("set end did not start sort/output");

endmodule
